// File: design/txop_pkg.sv
`timescale 1ns / 1ps

package txop_pkg;

  typedef enum logic [3:0] {
    PH_VER      = 4'd0,
    PH_INCNT    = 4'd1,
    PH_TXID     = 4'd2,
    PH_SSLEN    = 4'd3,
    PH_SSIG     = 4'd4,
    PH_SEQ      = 4'd5,
    PH_OUTCNT   = 4'd6,
    PH_VALUE    = 4'd7,
    PH_SPKLEN   = 4'd8,
    PH_SCRIPT   = 4'd9,
    PH_LOCK     = 4'd10,
    PH_DONE     = 4'd11,
    PH_INCNT_X  = 4'd12,
    PH_SSLEN_X  = 4'd13,
    PH_OUTCNT_X = 4'd14,
    PH_SPKLEN_X = 4'd15
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TRUNC    = 3'd1,
    ST_VARINT   = 3'd2,
    ST_IN_CNT   = 3'd3,
    ST_OUT_CNT  = 3'd4,
    ST_SCRIPT   = 3'd5,
    ST_TRAILING = 3'd6,
    ST_TOO_LONG = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    CLS_P2PKH = 2'd0,
    CLS_P2SH  = 2'd1,
    CLS_DATA  = 2'd2
  } script_class_e;

  typedef enum logic {
    REC_OUTPUT  = 1'b0,
    REC_VERDICT = 1'b1
  } record_kind_e;

  localparam logic [7:0] VARINT_16      = 8'hFD;
  localparam logic [7:0] OP_DUP         = 8'h76;
  localparam logic [7:0] OP_HASH160     = 8'ha9;
  localparam logic [7:0] OP_PUSH20      = 8'h14;
  localparam logic [7:0] OP_EQUALVERIFY = 8'h88;
  localparam logic [7:0] OP_CHECKSIG    = 8'hac;
  localparam logic [7:0] OP_EQUAL       = 8'h87;
  localparam logic [7:0] OP_DATA_MARK   = 8'h6a;

  localparam logic [15:0] P2PKH_LEN  = 16'd25;
  localparam logic [15:0] P2SH_LEN   = 16'd23;
  localparam logic [15:0] FIELD_FOUR = 16'd4;
  localparam logic [15:0] INPUT_HEAD = 16'd36;
  localparam logic [15:0] VALUE_LEN  = 16'd8;
  localparam logic [15:0] VARINT_EXT = 16'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic        record_kind;
    logic [7:0]  output_index;
    logic [63:0] amount;
    logic [1:0]  script_class;
    logic [7:0]  addr_version;
    logic [63:0] hash_high;
    logic [63:0] hash_mid;
    logic [31:0] hash_low;
    logic [7:0]  input_total;
    logic [7:0]  output_total;
    logic [2:0]  status;
    logic        final_res;
  } record_t;

  typedef struct packed {
    logic    out_vld;
    record_t out_rec;
    logic    ver_vld;
    record_t ver_rec;
  } push_t;

  function automatic logic [7:0] pkh_version(input logic [1:0] mode);
    logic [7:0] v;
    case (mode)
      2'd0:    v = 8'h1E;
      2'd1:    v = 8'h19;
      2'd2:    v = 8'h38;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] sh_version(input logic [1:0] mode);
    logic [7:0] v;
    case (mode)
      2'd0:    v = 8'h16;
      2'd1:    v = 8'h05;
      2'd2:    v = 8'h05;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// File: design/txop_parser.sv
`timescale 1ns / 1ps

module txop_parser #(
  parameter int MAX_OUTPUTS  = 8,
  parameter int MAX_TX_BYTES = 65535
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      data_byte_i,
  input  logic            end_of_tx_i,
  input  logic [1:0]      chain_sel_i,
  output txop_pkg::push_t push_o
);
  import txop_pkg::*;

  localparam logic [15:0] MaxOut = 16'(MAX_OUTPUTS);
  localparam logic [15:0] MaxTx  = 16'(MAX_TX_BYTES);

  phase_e        ph_q, ph_d;
  status_e       err_q, err_d;
  logic [15:0]   fbl_q, fbl_d;
  logic [7:0]    acc_q, acc_d;
  logic [7:0]    inl_q, inl_d;
  logic [7:0]    outl_q, outl_d;
  logic [7:0]    icnt_q, icnt_d;
  logic [7:0]    ocnt_q, ocnt_d;
  logic [63:0]   val_q, val_d;
  logic [15:0]   slen_q, slen_d;
  logic [15:0]   soff_q, soff_d;
  logic [2:0]    pf_q, pf_d;
  logic [15:0]   pos_q, pos_d;
  logic [159:0]  hash_q;
  logic          shift_hash;

  logic          vdone;
  phase_e        vbase;
  logic [15:0]   vval;
  logic          out_vld;
  logic          ver_vld;
  record_t       out_rec;
  record_t       ver_rec;
  status_e       verdict_st;

  always_comb begin
    ph_d       = ph_q;
    err_d      = err_q;
    fbl_d      = fbl_q;
    acc_d      = acc_q;
    inl_d      = inl_q;
    outl_d     = outl_q;
    icnt_d     = icnt_q;
    ocnt_d     = ocnt_q;
    val_d      = val_q;
    slen_d     = slen_q;
    soff_d     = soff_q;
    pf_d       = pf_q;
    pos_d      = pos_q;
    shift_hash = 1'b0;
    vdone      = 1'b0;
    vbase      = PH_SPKLEN;
    vval       = '0;
    out_vld    = 1'b0;
    ver_vld    = 1'b0;
    out_rec    = '0;
    ver_rec    = '0;
    verdict_st = ST_OK;

    if (accept_i && err_q == ST_OK) begin
      if (pos_q >= MaxTx) begin
        err_d = ST_TOO_LONG;
      end else begin
        pos_d = pos_q + 16'd1;
        case (ph_q)
          PH_VER, PH_TXID, PH_SEQ, PH_LOCK, PH_SSIG: begin
            fbl_d = fbl_q - 16'd1;
            if (fbl_d == '0) begin
              case (ph_q)
                PH_VER:  ph_d = PH_INCNT;
                PH_TXID: ph_d = PH_SSLEN;
                PH_SSIG: begin
                  ph_d  = PH_SEQ;
                  fbl_d = FIELD_FOUR;
                end
                PH_LOCK: ph_d = PH_DONE;
                default: begin
                  // end of sequence field closes one input
                  inl_d = inl_q - 8'd1;
                  if (inl_d != '0) begin
                    ph_d  = PH_TXID;
                    fbl_d = INPUT_HEAD;
                  end else begin
                    ph_d = PH_OUTCNT;
                  end
                end
              endcase
            end
          end
          PH_INCNT, PH_SSLEN, PH_OUTCNT, PH_SPKLEN: begin
            if (data_byte_i < VARINT_16) begin
              vdone = 1'b1;
              vbase = ph_q;
              vval  = {8'd0, data_byte_i};
            end else if (data_byte_i == VARINT_16) begin
              fbl_d = VARINT_EXT;
              acc_d = '0;
              case (ph_q)
                PH_INCNT:  ph_d = PH_INCNT_X;
                PH_SSLEN:  ph_d = PH_SSLEN_X;
                PH_OUTCNT: ph_d = PH_OUTCNT_X;
                default:   ph_d = PH_SPKLEN_X;
              endcase
            end else begin
              err_d = ST_VARINT;
            end
          end
          PH_INCNT_X, PH_SSLEN_X, PH_OUTCNT_X, PH_SPKLEN_X: begin
            if (fbl_q == VARINT_EXT) acc_d = data_byte_i;
            fbl_d = fbl_q - 16'd1;
            if (fbl_d == '0) begin
              vdone = 1'b1;
              vval  = {data_byte_i, acc_q};
              case (ph_q)
                PH_INCNT_X:  vbase = PH_INCNT;
                PH_SSLEN_X:  vbase = PH_SSLEN;
                PH_OUTCNT_X: vbase = PH_OUTCNT;
                default:     vbase = PH_SPKLEN;
              endcase
            end
          end
          PH_VALUE: begin
            // little-endian value: shift each byte in from the top
            val_d = {data_byte_i, val_q[63:8]};
            fbl_d = fbl_q - 16'd1;
            if (fbl_d == '0) ph_d = PH_SPKLEN;
          end
          PH_SCRIPT: begin
            if (pf_q[0]) begin
              if (soff_q == 16'd0 && data_byte_i != OP_DUP) pf_d[0] = 1'b0;
              if (soff_q == 16'd1 && data_byte_i != OP_HASH160) pf_d[0] = 1'b0;
              if (soff_q == 16'd2 && data_byte_i != OP_PUSH20) pf_d[0] = 1'b0;
              if (soff_q == 16'd23 && data_byte_i != OP_EQUALVERIFY) pf_d[0] = 1'b0;
              if (soff_q == 16'd24 && data_byte_i != OP_CHECKSIG) pf_d[0] = 1'b0;
              if (soff_q >= 16'd3 && soff_q <= 16'd22) shift_hash = 1'b1;
            end
            if (pf_q[1]) begin
              if (soff_q == 16'd0 && data_byte_i != OP_HASH160) pf_d[1] = 1'b0;
              if (soff_q == 16'd1 && data_byte_i != OP_PUSH20) pf_d[1] = 1'b0;
              if (soff_q == 16'd22 && data_byte_i != OP_EQUAL) pf_d[1] = 1'b0;
              if (soff_q >= 16'd2 && soff_q <= 16'd21) shift_hash = 1'b1;
            end
            if (pf_q[2] && soff_q == 16'd0 && data_byte_i != OP_DATA_MARK) pf_d[2] = 1'b0;
            soff_d = soff_q + 16'd1;
            if (soff_d == slen_q) begin
              out_rec.record_kind  = REC_OUTPUT;
              out_rec.output_index = ocnt_q - outl_q;
              out_rec.amount       = val_q;
              out_rec.hash_high    = hash_q[159:96];
              out_rec.hash_mid     = hash_q[95:32];
              out_rec.hash_low     = hash_q[31:0];
              if (pf_d[0]) begin
                out_vld              = 1'b1;
                out_rec.script_class = CLS_P2PKH;
                out_rec.addr_version = pkh_version(chain_sel_i);
              end else if (pf_d[1]) begin
                out_vld              = 1'b1;
                out_rec.script_class = CLS_P2SH;
                out_rec.addr_version = sh_version(chain_sel_i);
              end else if (pf_d[2]) begin
                out_vld              = 1'b1;
                out_rec.script_class = CLS_DATA;
                out_rec.hash_high    = '0;
                out_rec.hash_mid     = '0;
                out_rec.hash_low     = '0;
              end else begin
                err_d = ST_SCRIPT;
              end
              if (out_vld) begin
                outl_d = outl_q - 8'd1;
                if (outl_d != '0) begin
                  ph_d  = PH_VALUE;
                  fbl_d = VALUE_LEN;
                end else begin
                  ph_d  = PH_LOCK;
                  fbl_d = FIELD_FOUR;
                end
              end
            end
          end
          default: err_d = ST_TRAILING;
        endcase

        if (vdone) begin
          case (vbase)
            PH_INCNT: begin
              if (vval == '0 || vval > 16'd255) begin
                err_d = ST_IN_CNT;
              end else begin
                icnt_d = vval[7:0];
                inl_d  = vval[7:0];
                ph_d   = PH_TXID;
                fbl_d  = INPUT_HEAD;
              end
            end
            PH_SSLEN: begin
              if (vval == '0) begin
                ph_d  = PH_SEQ;
                fbl_d = FIELD_FOUR;
              end else begin
                ph_d  = PH_SSIG;
                fbl_d = vval;
              end
            end
            PH_OUTCNT: begin
              if (vval == '0 || vval > MaxOut) begin
                err_d = ST_OUT_CNT;
              end else begin
                ocnt_d = vval[7:0];
                outl_d = vval[7:0];
                ph_d   = PH_VALUE;
                fbl_d  = VALUE_LEN;
              end
            end
            default: begin
              if (vval == '0) begin
                err_d = ST_SCRIPT;
              end else begin
                slen_d = vval;
                soff_d = '0;
                pf_d   = {1'b1, vval == P2SH_LEN, vval == P2PKH_LEN};
                ph_d   = PH_SCRIPT;
              end
            end
          endcase
        end
      end
    end

    if (accept_i && end_of_tx_i) begin
      verdict_st = err_d;
      if (err_d == ST_OK && ph_d != PH_DONE) verdict_st = ST_TRUNC;
      ver_vld              = 1'b1;
      ver_rec.record_kind  = REC_VERDICT;
      ver_rec.input_total  = icnt_d;
      ver_rec.output_total = ocnt_d;
      ver_rec.status       = verdict_st;
      ver_rec.final_res    = 1'b1;
      // back to the start state for the next transaction
      ph_d   = PH_VER;
      err_d  = ST_OK;
      fbl_d  = FIELD_FOUR;
      acc_d  = '0;
      inl_d  = '0;
      outl_d = '0;
      icnt_d = '0;
      ocnt_d = '0;
      val_d  = '0;
      slen_d = '0;
      soff_d = '0;
      pf_d   = '0;
      pos_d  = '0;
    end
    out_rec.final_res = !ver_vld;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_VER;
      err_q  <= ST_OK;
      fbl_q  <= FIELD_FOUR;
      acc_q  <= '0;
      inl_q  <= '0;
      outl_q <= '0;
      icnt_q <= '0;
      ocnt_q <= '0;
      val_q  <= '0;
      slen_q <= '0;
      soff_q <= '0;
      pf_q   <= '0;
      pos_q  <= '0;
    end else begin
      ph_q   <= ph_d;
      err_q  <= err_d;
      fbl_q  <= fbl_d;
      acc_q  <= acc_d;
      inl_q  <= inl_d;
      outl_q <= outl_d;
      icnt_q <= icnt_d;
      ocnt_q <= ocnt_d;
      val_q  <= val_d;
      slen_q <= slen_d;
      soff_q <= soff_d;
      pf_q   <= pf_d;
      pos_q  <= pos_d;
    end
  end

  // hash160 bytes arrive in order, first byte ends up on top
  always_ff @(posedge clk_i) begin
    if (shift_hash) hash_q <= {hash_q[151:0], data_byte_i};
  end

  assign push_o.out_vld = out_vld;
  assign push_o.out_rec = out_rec;
  assign push_o.ver_vld = ver_vld;
  assign push_o.ver_rec = ver_rec;

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && end_of_tx_i |=> ph_q == PH_VER && err_q == ST_OK && pos_q == '0)
    else $error("parser did not restart after the final byte");

  a_error_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q != ST_OK && !(accept_i && end_of_tx_i) |=> err_q == $past(err_q))
    else $error("latched error changed before the final byte");

  a_output_from_script: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld |-> accept_i && ph_q == PH_SCRIPT && err_q == ST_OK)
    else $error("output record outside of a script");

endmodule

// File: design/txop_queue.sv
`timescale 1ns / 1ps

module txop_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  txop_pkg::push_t   push_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              stall_i,
  output txop_pkg::record_t head_o
);
  import txop_pkg::*;

  localparam logic [QUEUE_AW:0] Depth = (QUEUE_AW + 1)'(QUEUE_DEPTH);

  record_t               mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_q, wr_d;
  logic [QUEUE_AW-1:0]   rd_q, rd_d;
  logic [QUEUE_AW:0]     cnt_q, cnt_d;
  logic [QUEUE_AW-1:0]   wr_second;
  logic                  pop;
  logic [QUEUE_AW:0]     push_n;

  assign pop       = valid_o && !stall_i;
  assign push_n    = (QUEUE_AW + 1)'(push_i.out_vld) + (QUEUE_AW + 1)'(push_i.ver_vld);
  assign wr_second = wr_q + QUEUE_AW'(push_i.out_vld);
  assign wr_d      = wr_q + push_n[QUEUE_AW-1:0];
  assign rd_d      = rd_q + QUEUE_AW'(pop);
  assign cnt_d     = cnt_q + push_n - (QUEUE_AW + 1)'(pop);

  // room for two records is kept so a final byte can always land
  assign full_o  = cnt_q > Depth - 2;
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.out_vld) mem_q[wr_q] <= push_i.out_rec;
    if (push_i.ver_vld) mem_q[wr_second] <= push_i.ver_rec;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Depth)
    else $error("record queue overflow");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.out_vld || push_i.ver_vld) |-> cnt_q <= Depth - 2)
    else $error("request pushed while queue was full");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push_i.out_vld && !push_i.ver_vld |=> cnt_q == $past(cnt_q) - 1)
    else $error("queue count wrong after a pop");

endmodule

// File: design/transaction_output_parser.sv
// a record is registered into the record queue when its byte is accepted and is offered after the records ahead of it
// throughput: one byte per cycle while the input is not stalled; a final byte that closes an output yields two records
// the input stalls while the four-entry record queue holds more than two records
// reset: parse state returns to the version field, chain select clears to 0, queue empties
`timescale 1ns / 1ps

module transaction_output_parser #(
  parameter int MAX_OUTPUTS  = 8,
  parameter int MAX_TX_BYTES = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_tx_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        record_kind_o,
  output logic [7:0]  output_index_o,
  output logic [63:0] amount_o,
  output logic [1:0]  script_class_o,
  output logic [7:0]  addr_version_o,
  output logic [63:0] hash_high_o,
  output logic [63:0] hash_mid_o,
  output logic [31:0] hash_low_o,
  output logic [7:0]  input_total_o,
  output logic [7:0]  output_total_o,
  output logic [2:0]  status_o,
  output logic        final_res_o
);
  import txop_pkg::*;

  logic    [1:0] chain_sel_q;
  logic          accept;
  logic          full;
  push_t         push;
  record_t       head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_sel_q <= '0;
    end else if (cfg_we_i) begin
      chain_sel_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  txop_parser #(
    .MAX_OUTPUTS (MAX_OUTPUTS),
    .MAX_TX_BYTES(MAX_TX_BYTES)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .data_byte_i(data_byte_i),
    .end_of_tx_i(end_of_tx_i),
    .chain_sel_i(chain_sel_q),
    .push_o     (push)
  );

  txop_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .head_o (head)
  );

  assign record_kind_o  = head.record_kind;
  assign output_index_o = head.output_index;
  assign amount_o       = head.amount;
  assign script_class_o = head.script_class;
  assign addr_version_o = head.addr_version;
  assign hash_high_o    = head.hash_high;
  assign hash_mid_o     = head.hash_mid;
  assign hash_low_o     = head.hash_low;
  assign input_total_o  = head.input_total;
  assign output_total_o = head.output_total;
  assign status_o       = head.status;
  assign final_res_o    = head.final_res;

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import txop_pkg::*;

  localparam int MAX_OUTPUTS    = 8;
  localparam int MAX_TX_BYTES   = 65535;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;

  typedef enum int {
    SK_P2PKH,
    SK_P2SH,
    SK_DATA,
    SK_JUNK,
    SK_NEAR,
    SK_EMPTY
  } script_kind_e;

  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_e;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_wdata = 2'd0;
  logic        in_valid = 1'b0;
  logic [7:0]  data_byte = 8'd0;
  logic        end_of_tx = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        record_kind_o;
  logic [7:0]  output_index_o;
  logic [63:0] amount_o;
  logic [1:0]  script_class_o;
  logic [7:0]  addr_version_o;
  logic [63:0] hash_high_o;
  logic [63:0] hash_mid_o;
  logic [31:0] hash_low_o;
  logic [7:0]  input_total_o;
  logic [7:0]  output_total_o;
  logic [2:0]  status_o;
  logic        final_res_o;

  transaction_output_parser #(
    .MAX_OUTPUTS (MAX_OUTPUTS),
    .MAX_TX_BYTES(MAX_TX_BYTES)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte),
    .end_of_tx_i   (end_of_tx),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .record_kind_o (record_kind_o),
    .output_index_o(output_index_o),
    .amount_o      (amount_o),
    .script_class_o(script_class_o),
    .addr_version_o(addr_version_o),
    .hash_high_o   (hash_high_o),
    .hash_mid_o    (hash_mid_o),
    .hash_low_o    (hash_low_o),
    .input_total_o (input_total_o),
    .output_total_o(output_total_o),
    .status_o      (status_o),
    .final_res_o   (final_res_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // parser mirror
  phase_e      ph;
  logic [15:0] fld_left;
  logic [15:0] vint_acc;
  logic [7:0]  in_left;
  logic [7:0]  out_left;
  logic [7:0]  in_cnt;
  logic [7:0]  out_cnt;
  logic [63:0] value_acc;
  logic [15:0] spk_len;
  logic [15:0] spk_off;
  logic [2:0]  pat;
  logic [7:0]  hash_mem [20];
  status_e     err;
  logic [15:0] byte_pos;
  logic [1:0]  chain_sel;
  logic        have_out;
  record_t     out_rec;

  record_t     expected_records [$];

  int          idle_pct = 0;
  int          stall_pct = 0;
  bit          no_gaps = 0;
  bit          hold_req = 0;
  int          hold_left = 0;
  fill_e       hash_fill = FILL_RANDOM;
  logic [7:0]  tx_buf [$];

  int          bytes_sent = 0;
  int          tx_sent = 0;
  int          records_predicted = 0;
  int          records_checked = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          verdicts [8];

  function automatic logic [7:0] coin_version(input logic [1:0] mode, input logic script_hash);
    logic [7:0] v;
    v = 8'h00;
    if (!script_hash) begin
      if (mode == 2'd0) v = 8'h1E;
      else if (mode == 2'd1) v = 8'h19;
      else if (mode == 2'd2) v = 8'h38;
    end else begin
      if (mode == 2'd0) v = 8'h16;
      else if (mode == 2'd1 || mode == 2'd2) v = 8'h05;
    end
    return v;
  endfunction

  task automatic restart_parse();
    ph = PH_VER;
    fld_left = FIELD_FOUR;
    vint_acc = '0;
    in_left = '0;
    out_left = '0;
    in_cnt = '0;
    out_cnt = '0;
    value_acc = '0;
    spk_len = '0;
    spk_off = '0;
    pat = '0;
    for (int i = 0; i < 20; i++) hash_mem[i] = 8'h00;
    err = ST_OK;
    byte_pos = '0;
  endtask

  task automatic close_varint(input phase_e base, input logic [15:0] v);
    case (base)
      PH_INCNT: begin
        if (v == 0 || v > 255) begin
          err = ST_IN_CNT;
        end else begin
          in_cnt = v[7:0];
          in_left = v[7:0];
          ph = PH_TXID;
          fld_left = INPUT_HEAD;
        end
      end
      PH_SSLEN: begin
        if (v == 0) begin
          ph = PH_SEQ;
          fld_left = FIELD_FOUR;
        end else begin
          ph = PH_SSIG;
          fld_left = v;
        end
      end
      PH_OUTCNT: begin
        if (v == 0 || v > MAX_OUTPUTS) begin
          err = ST_OUT_CNT;
        end else begin
          out_cnt = v[7:0];
          out_left = v[7:0];
          ph = PH_VALUE;
          fld_left = VALUE_LEN;
          value_acc = '0;
        end
      end
      default: begin
        if (v == 0) begin
          err = ST_SCRIPT;
        end else begin
          spk_len = v;
          spk_off = '0;
          pat = {1'b1, v == P2SH_LEN, v == P2PKH_LEN};
          ph = PH_SCRIPT;
        end
      end
    endcase
  endtask

  task automatic open_varint(input phase_e base, input phase_e ext, input logic [7:0] b);
    if (b < VARINT_16) begin
      close_varint(base, {8'h00, b});
    end else if (b == VARINT_16) begin
      fld_left = VARINT_EXT;
      vint_acc = '0;
      ph = ext;
    end else begin
      err = ST_VARINT;
    end
  endtask

  task automatic match_script(input logic [7:0] b);
    int o;
    bit ok;
    o = int'(spk_off);
    if (pat[0]) begin
      ok = 1;
      if (o == 0) ok = (b == OP_DUP);
      else if (o == 1) ok = (b == OP_HASH160);
      else if (o == 2) ok = (b == OP_PUSH20);
      else if (o <= 22) hash_mem[o - 3] = b;
      else if (o == 23) ok = (b == OP_EQUALVERIFY);
      else if (o == 24) ok = (b == OP_CHECKSIG);
      if (!ok) pat[0] = 1'b0;
    end
    if (pat[1]) begin
      ok = 1;
      if (o == 0) ok = (b == OP_HASH160);
      else if (o == 1) ok = (b == OP_PUSH20);
      else if (o <= 21) hash_mem[o - 2] = b;
      else if (o == 22) ok = (b == OP_EQUAL);
      if (!ok) pat[1] = 1'b0;
    end
    if (pat[2] && o == 0 && b != OP_DATA_MARK) pat[2] = 1'b0;
  endtask

  task automatic close_script();
    record_t r;
    r = '0;
    r.record_kind = REC_OUTPUT;
    r.output_index = out_cnt - out_left;
    r.amount = value_acc;
    if (pat[0] || pat[1]) begin
      r.script_class = pat[0] ? CLS_P2PKH : CLS_P2SH;
      r.addr_version = coin_version(chain_sel, !pat[0]);
      for (int i = 0; i < 8; i++) r.hash_high = {r.hash_high[55:0], hash_mem[i]};
      for (int i = 8; i < 16; i++) r.hash_mid = {r.hash_mid[55:0], hash_mem[i]};
      for (int i = 16; i < 20; i++) r.hash_low = {r.hash_low[23:0], hash_mem[i]};
    end else if (pat[2]) begin
      r.script_class = CLS_DATA;
    end else begin
      err = ST_SCRIPT;
      return;
    end
    out_rec = r;
    have_out = 1;
    out_left = out_left - 8'd1;
    if (out_left != 0) begin
      ph = PH_VALUE;
      fld_left = VALUE_LEN;
      value_acc = '0;
    end else begin
      ph = PH_LOCK;
      fld_left = FIELD_FOUR;
    end
  endtask

  task automatic advance_parse(input logic [7:0] b);
    int k;
    case (ph)
      PH_VER, PH_TXID, PH_SEQ, PH_LOCK, PH_SSIG: begin
        fld_left = fld_left - 16'd1;
        if (fld_left == 0) begin
          case (ph)
            PH_VER:  ph = PH_INCNT;
            PH_TXID: ph = PH_SSLEN;
            PH_SSIG: begin
              ph = PH_SEQ;
              fld_left = FIELD_FOUR;
            end
            PH_LOCK: ph = PH_DONE;
            default: begin
              in_left = in_left - 8'd1;
              if (in_left != 0) begin
                ph = PH_TXID;
                fld_left = INPUT_HEAD;
              end else begin
                ph = PH_OUTCNT;
              end
            end
          endcase
        end
      end
      PH_INCNT:  open_varint(PH_INCNT, PH_INCNT_X, b);
      PH_SSLEN:  open_varint(PH_SSLEN, PH_SSLEN_X, b);
      PH_OUTCNT: open_varint(PH_OUTCNT, PH_OUTCNT_X, b);
      PH_SPKLEN: open_varint(PH_SPKLEN, PH_SPKLEN_X, b);
      PH_INCNT_X, PH_SSLEN_X, PH_OUTCNT_X, PH_SPKLEN_X: begin
        if (fld_left == 2) vint_acc = {8'h00, b};
        else vint_acc = vint_acc | {b, 8'h00};
        fld_left = fld_left - 16'd1;
        if (fld_left == 0) begin
          case (ph)
            PH_INCNT_X:  close_varint(PH_INCNT, vint_acc);
            PH_SSLEN_X:  close_varint(PH_SSLEN, vint_acc);
            PH_OUTCNT_X: close_varint(PH_OUTCNT, vint_acc);
            default:     close_varint(PH_SPKLEN, vint_acc);
          endcase
        end
      end
      PH_VALUE: begin
        k = (8 - int'(fld_left)) & 7;
        value_acc = value_acc | ({56'd0, b} << (8 * k));
        fld_left = fld_left - 16'd1;
        if (fld_left == 0) ph = PH_SPKLEN;
      end
      PH_SCRIPT: begin
        match_script(b);
        spk_off = spk_off + 16'd1;
        if (spk_off == spk_len) close_script();
      end
      default: err = ST_TRAILING;
    endcase
  endtask

  // expected records for one accepted byte, queued in order
  task automatic parse_byte(input logic [7:0] b, input logic last);
    record_t v;
    have_out = 0;
    if (err == ST_OK) begin
      if (byte_pos >= MAX_TX_BYTES) begin
        err = ST_TOO_LONG;
      end else begin
        byte_pos = byte_pos + 16'd1;
        advance_parse(b);
      end
    end
    if (last) begin
      v = '0;
      v.record_kind = REC_VERDICT;
      v.input_total = in_cnt;
      v.output_total = out_cnt;
      v.status = err;
      if (err == ST_OK && ph != PH_DONE) v.status = ST_TRUNC;
      v.final_res = 1'b1;
      if (have_out) expected_records.push_back(out_rec);
      expected_records.push_back(v);
      records_predicted += have_out ? 2 : 1;
      restart_parse();
    end else if (have_out) begin
      out_rec.final_res = 1'b1;
      expected_records.push_back(out_rec);
      records_predicted++;
    end
  endtask

  function automatic string rec_text(input record_t r);
    return $sformatf("kind %0d idx %0d amt %h cls %0d ver %h hash %h_%h_%h in %0d out %0d st %0d fin %0d",
                     r.record_kind, r.output_index, r.amount, r.script_class, r.addr_version,
                     r.hash_high, r.hash_mid, r.hash_low, r.input_total, r.output_total,
                     r.status, r.final_res);
  endfunction

  always @(posedge clk_i) begin : check_records
    record_t got;
    record_t want;
    string   bad;
    if (rst_n && out_valid_o && !out_stall) begin
      got.record_kind = record_kind_o;
      got.output_index = output_index_o;
      got.amount = amount_o;
      got.script_class = script_class_o;
      got.addr_version = addr_version_o;
      got.hash_high = hash_high_o;
      got.hash_mid = hash_mid_o;
      got.hash_low = hash_low_o;
      got.input_total = input_total_o;
      got.output_total = output_total_o;
      got.status = status_o;
      got.final_res = final_res_o;
      records_checked++;
      if (expected_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected record: %s", rec_text(got));
      end else begin
        want = expected_records.pop_front();
        bad = "";
        if (got.record_kind !== want.record_kind) bad = {bad, " record_kind"};
        if (got.output_index !== want.output_index) bad = {bad, " output_index"};
        if (got.amount !== want.amount) bad = {bad, " amount"};
        if (got.script_class !== want.script_class) bad = {bad, " script_class"};
        if (got.addr_version !== want.addr_version) bad = {bad, " addr_version"};
        if (got.hash_high !== want.hash_high) bad = {bad, " hash_high"};
        if (got.hash_mid !== want.hash_mid) bad = {bad, " hash_mid"};
        if (got.hash_low !== want.hash_low) bad = {bad, " hash_low"};
        if (got.input_total !== want.input_total) bad = {bad, " input_total"};
        if (got.output_total !== want.output_total) bad = {bad, " output_total"};
        if (got.status !== want.status) bad = {bad, " status"};
        if (got.final_res !== want.final_res) bad = {bad, " final_res"};
        if (bad != "") begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("record %0d mismatch in%s", records_checked, bad);
            $display("  expected %s", rec_text(want));
            $display("  actual   %s", rec_text(got));
          end
        end
        if (want.record_kind == REC_VERDICT) verdicts[want.status]++;
      end
    end
  end

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("no handshake for %0d cycles", quiet_cycles);
      $display("transaction_output_parser regression: fail");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!no_gaps) begin
      while ($urandom_range(0, 99) < idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_tx <= last;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    parse_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_tx();
    no_gaps = ($urandom_range(0, 7) == 0);
    for (int i = 0; i < tx_buf.size(); i++) send_byte(tx_buf[i], i == tx_buf.size() - 1);
    tx_sent++;
    tx_buf.delete();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_records.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_coin(input logic [1:0] m);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk_i);
    chain_sel = m;
    cfg_we <= 1'b0;
  endtask

  // transaction builders
  task automatic put_rand(input int n);
    for (int i = 0; i < n; i++) tx_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic put_varint(input int v, input bit wide);
    if (!wide && v < VARINT_16) begin
      tx_buf.push_back(v[7:0]);
    end else begin
      tx_buf.push_back(VARINT_16);
      tx_buf.push_back(v[7:0]);
      tx_buf.push_back(v[15:8]);
    end
  endtask

  function automatic logic [7:0] hash_byte();
    if (hash_fill == FILL_ZERO) return 8'h00;
    if (hash_fill == FILL_ONES) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic put_input(input int sslen, input bit wide);
    put_rand(36);
    put_varint(sslen, wide);
    put_rand(sslen);
    put_rand(4);
  endtask

  task automatic put_head(input int n_in, input bit wide);
    put_rand(4);
    put_varint(n_in, wide);
    for (int i = 0; i < n_in; i++) put_input($urandom_range(0, 6), $urandom_range(0, 9) == 0);
  endtask

  task automatic put_script(input script_kind_e kind, input int len, input bit wide);
    logic [7:0] s [$];
    int         pos;
    case (kind)
      SK_P2PKH, SK_NEAR: begin
        if (kind == SK_NEAR && $urandom_range(0, 1)) begin
          s.push_back(OP_HASH160);
          s.push_back(OP_PUSH20);
          for (int i = 0; i < 20; i++) s.push_back(hash_byte());
          s.push_back(OP_EQUAL);
        end else begin
          s.push_back(OP_DUP);
          s.push_back(OP_HASH160);
          s.push_back(OP_PUSH20);
          for (int i = 0; i < 20; i++) s.push_back(hash_byte());
          s.push_back(OP_EQUALVERIFY);
          s.push_back(OP_CHECKSIG);
        end
        if (kind == SK_NEAR) begin
          // break one opcode of the template, never a hash byte
          pos = $urandom_range(0, 3);
          if (s.size() == 25) pos = (pos < 3) ? pos : 23 + $urandom_range(0, 1);
          else pos = (pos < 2) ? pos : 22;
          s[pos] = s[pos] ^ 8'($urandom_range(1, 255));
        end
      end
      SK_P2SH: begin
        s.push_back(OP_HASH160);
        s.push_back(OP_PUSH20);
        for (int i = 0; i < 20; i++) s.push_back(hash_byte());
        s.push_back(OP_EQUAL);
      end
      SK_DATA, SK_JUNK: begin
        if (len == 0) len = $urandom_range(1, 40);
        for (int i = 0; i < len; i++) s.push_back(8'($urandom_range(0, 255)));
        if (kind == SK_DATA) s[0] = OP_DATA_MARK;
      end
      default: ;
    endcase
    put_varint(s.size(), wide);
    for (int i = 0; i < s.size(); i++) tx_buf.push_back(s[i]);
  endtask

  task automatic put_output(input script_kind_e kind, input logic [63:0] amt);
    for (int i = 0; i < 8; i++) tx_buf.push_back(amt[8*i +: 8]);
    put_script(kind, 0, $urandom_range(0, 9) == 0);
  endtask

  function automatic logic [63:0] pick_amount();
    case ($urandom_range(0, 9))
      0:       return 64'd0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic script_kind_e pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return SK_P2PKH;
    if (r < 65) return SK_P2SH;
    if (r < 85) return SK_DATA;
    if (r < 90) return SK_JUNK;
    if (r < 97) return SK_NEAR;
    return SK_EMPTY;
  endfunction

  task automatic put_random_tx();
    int         n_in;
    int         n_out;
    int         pos;
    logic [7:0] dropped;
    n_in = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 6) : $urandom_range(1, 2);
    n_out = $urandom_range(1, MAX_OUTPUTS);
    put_head(n_in, $urandom_range(0, 9) == 0);
    put_varint(n_out, $urandom_range(0, 9) == 0);
    for (int i = 0; i < n_out; i++) put_output(pick_kind(), pick_amount());
    put_rand(4);
    // a fifth of the requests are damaged
    case ($urandom_range(0, 19))
      0: begin
        pos = $urandom_range(1, tx_buf.size() - 1);
        while (tx_buf.size() > pos) dropped = tx_buf.pop_back();
      end
      1: put_rand($urandom_range(1, 3));
      2: begin
        pos = $urandom_range(0, tx_buf.size() - 1);
        tx_buf[pos] = 8'($urandom_range(0, 255));
      end
      3: begin
        tx_buf.delete();
        put_rand($urandom_range(1, 20));
      end
      default: ;
    endcase
  endtask

  // directed tests
  task automatic test_output_classes();
    set_coin(2'd0);
    put_head(1, 0);
    put_varint(3, 0);
    hash_fill = FILL_ZERO;
    put_output(SK_P2PKH, 64'd0);
    hash_fill = FILL_ONES;
    put_output(SK_P2SH, '1);
    hash_fill = FILL_RANDOM;
    put_output(SK_DATA, {$urandom, $urandom});
    put_rand(4);
    send_tx();
    // single-byte data carrier
    put_head(1, 0);
    put_varint(1, 0);
    put_rand(8);
    put_script(SK_DATA, 1, 0);
    put_rand(4);
    send_tx();
  endtask

  task automatic test_coin_modes();
    logic [1:0] modes [4];
    modes = '{2'd1, 2'd2, 2'd3, 2'd0};
    for (int m = 0; m < 4; m++) begin
      set_coin(modes[m]);
      put_head(1, 0);
      put_varint(2, 0);
      put_output(SK_P2PKH, pick_amount());
      put_output(SK_P2SH, pick_amount());
      put_rand(4);
      send_tx();
    end
  endtask

  task automatic test_varint_forms();
    // non-canonical wide forms everywhere
    put_rand(4);
    put_varint(1, 1);
    put_input(3, 1);
    put_varint(2, 1);
    put_rand(8);
    put_script(SK_P2PKH, 0, 1);
    put_rand(8);
    put_script(SK_DATA, 0, 1);
    put_rand(4);
    send_tx();
    // 0xFE input count
    put_rand(4);
    tx_buf.push_back(8'hFE);
    put_rand(6);
    send_tx();
    // 0xFF output count
    put_head(1, 0);
    tx_buf.push_back(8'hFF);
    put_rand(5);
    send_tx();
    // 0xFE script length
    put_head(1, 0);
    put_varint(1, 0);
    put_rand(8);
    tx_buf.push_back(8'hFE);
    put_rand(3);
    send_tx();
    // wide zero script length
    put_head(1, 0);
    put_varint(1, 0);
    put_rand(8);
    put_varint(0, 1);
    put_rand(4);
    send_tx();
  endtask

  task automatic test_count_limits();
    put_rand(4);
    put_varint(0, 0);
    put_rand(5);
    send_tx();
    put_rand(4);
    put_varint(256, 1);
    put_rand(5);
    send_tx();
    // largest input count is taken, the request is cut short after it
    put_rand(4);
    put_varint(255, 0);
    put_rand(5);
    send_tx();
    put_head(1, 0);
    put_varint(0, 0);
    put_rand(4);
    send_tx();
    put_head(2, 0);
    put_varint(MAX_OUTPUTS + 1, 0);
    put_rand(9);
    send_tx();
    put_head(1, 0);
    put_varint(16'hFFFF, 1);
    put_rand(3);
    send_tx();
    put_head(1, 0);
    put_varint(MAX_OUTPUTS, 0);
    for (int i = 0; i < MAX_OUTPUTS; i++) put_output(script_kind_e'(i % 3), pick_amount());
    put_rand(4);
    send_tx();
  endtask

  task automatic test_script_rules();
    script_kind_e bad_kinds [4];
    bad_kinds = '{SK_EMPTY, SK_JUNK, SK_NEAR, SK_NEAR};
    for (int i = 0; i < 4; i++) begin
      put_head(1, 0);
      put_varint(2, 0);
      put_output(SK_P2PKH, pick_amount());
      put_rand(8);
      if (bad_kinds[i] == SK_JUNK) begin
        // starts like neither template nor a data carrier
        put_varint(5, 0);
        tx_buf.push_back(8'h00);
        put_rand(4);
      end else begin
        put_script(bad_kinds[i], 0, 0);
      end
      put_rand(12);
      send_tx();
    end
    // data carrier of key-hash length
    put_head(1, 0);
    put_varint(1, 0);
    put_rand(8);
    put_script(SK_DATA, P2PKH_LEN, 0);
    put_rand(4);
    send_tx();
  endtask

  task automatic test_framing();
    logic [7:0] dropped;
    // lone byte
    put_rand(1);
    send_tx();
    // cut inside the locktime
    put_head(1, 0);
    put_varint(1, 0);
    put_output(SK_DATA, pick_amount());
    put_rand(2);
    send_tx();
    // cut on the last script byte: output and verdict from one byte
    put_head(1, 0);
    put_varint(2, 0);
    put_output(SK_P2PKH, pick_amount());
    put_output(SK_P2SH, pick_amount());
    send_tx();
    // trailing bytes after the locktime
    put_head(1, 0);
    put_varint(1, 0);
    put_output(SK_P2SH, pick_amount());
    put_rand(4 + 3);
    send_tx();
    // cut in the middle of an input
    put_head(2, 0);
    while (tx_buf.size() > 30) dropped = tx_buf.pop_back();
    send_tx();
  endtask

  task automatic test_backpressure();
    drain();
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1;
    for (int t = 0; t < 2; t++) begin
      put_head(1, 0);
      put_varint(MAX_OUTPUTS, 0);
      for (int i = 0; i < MAX_OUTPUTS; i++) begin
        put_rand(8);
        put_script(SK_DATA, 1, 0);
      end
      put_rand(4);
      send_tx();
    end
    drain();
  endtask

  task automatic test_random(input int idle, input int stall, input logic [1:0] mode,
                             input int nbytes);
    int first_byte;
    set_coin(mode);
    idle_pct = idle;
    stall_pct = stall;
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < nbytes) begin
      put_random_tx();
      send_tx();
    end
    drain();
    idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    bit leftover;
    for (int i = 0; i < 8; i++) verdicts[i] = 0;
    chain_sel = 2'd0;
    restart_parse();
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    test_output_classes();
    test_coin_modes();
    test_varint_forms();
    test_count_limits();
    test_script_rules();
    test_framing();
    test_backpressure();
    test_random(0, 0, 2'd0, 100);
    test_random(87, 0, 2'd1, 100);
    test_random(0, 87, 2'd2, 100);
    test_random(27, 27, 2'd3, 100);

    drain();
    repeat (8) @(posedge clk_i);
    leftover = (expected_records.size() != 0);
    if (leftover) $display("%0d expected records never arrived", expected_records.size());
    $display("ran %0d transactions, %0d bytes, %0d records checked, %0d mismatches",
             tx_sent, bytes_sent, records_checked, mismatches);
    $display("verdicts ok %0d trunc %0d varint %0d incnt %0d outcnt %0d script %0d trail %0d long %0d",
             verdicts[0], verdicts[1], verdicts[2], verdicts[3], verdicts[4], verdicts[5],
             verdicts[6], verdicts[7]);
    if (mismatches == 0 && !leftover) begin
      $display("transaction_output_parser regression: pass");
    end else begin
      $display("transaction_output_parser regression: fail");
    end
    $finish;
  end

endmodule
